FILE: hw/rtl/fdm_pkg.sv
// Shared types for the signed floored divide/modulo pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fdm_pkg;

  // Side information that travels with each transaction down the chain.
  typedef struct packed {
    logic neg_a;  // dividend was negative
    logic neg_b;  // divisor was negative
    logic zero;   // divisor was zero
  } fdm_flags_t;

endpackage

FILE: hw/rtl/fdm_prep.sv
// Input stage: takes operand magnitudes and sign flags into a register.
// Depends on fdm_pkg.
`timescale 1ns / 1ps

module fdm_prep import fdm_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [WIDTH-1:0] dividend,
  input  logic signed [WIDTH-1:0] divisor,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic        [WIDTH-1:0] rem,
  output logic        [WIDTH-1:0] qd,
  output logic        [WIDTH-1:0] mb,
  output logic        [WIDTH-1:0] b,
  output fdm_flags_t              flags
);

  logic [WIDTH-1:0] a_u;
  logic [WIDTH-1:0] b_u;
  logic             neg_a;
  logic             neg_b;

  // Operand signs and magnitudes.
  assign a_u   = $unsigned(dividend);
  assign b_u   = $unsigned(divisor);
  assign neg_a = a_u[WIDTH-1];
  assign neg_b = b_u[WIDTH-1];

  // The stage holds while it has a transaction that the next stage refuses.
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rem         <= '0;
      qd          <= neg_a ? ({WIDTH{1'b0}} - a_u) : a_u;
      mb          <= neg_b ? ({WIDTH{1'b0}} - b_u) : b_u;
      b           <= b_u;
      flags.neg_a <= neg_a;
      flags.neg_b <= neg_b;
      flags.zero  <= (b_u == '0);
    end
  end

endmodule

FILE: hw/rtl/fdm_cell.sv
// One restoring division step: develops a single quotient bit per cell.
// Depends on fdm_pkg.
`timescale 1ns / 1ps

module fdm_cell import fdm_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] rem_in,
  input  logic [WIDTH-1:0] qd_in,
  input  logic [WIDTH-1:0] mb_in,
  input  logic [WIDTH-1:0] b_in,
  input  fdm_flags_t       flags_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] qd,
  output logic [WIDTH-1:0] mb,
  output logic [WIDTH-1:0] b,
  output fdm_flags_t       flags
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;
  logic             fits;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] qd_next;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign shifted  = {rem_in, qd_in[WIDTH-1]};
  assign trial    = shifted - {1'b0, mb_in};
  assign fits     = !trial[WIDTH];
  assign rem_next = fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
  assign qd_next  = {qd_in[WIDTH-2:0], fits};

  // Hold only while full and the neighbor downstream refuses.
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rem   <= rem_next;
      qd    <= qd_next;
      mb    <= mb_in;
      b     <= b_in;
      flags <= flags_in;
    end
  end

endmodule

FILE: hw/rtl/fdm_post.sv
// Output stage: applies signs, floors toward minus infinity, holds the result.
// Depends on fdm_pkg.
`timescale 1ns / 1ps

module fdm_post import fdm_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic        [WIDTH-1:0] ur,
  input  logic        [WIDTH-1:0] uq,
  input  logic        [WIDTH-1:0] b_in,
  input  fdm_flags_t              flags_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WIDTH-1:0] quotient,
  output logic signed [WIDTH-1:0] remainder,
  output logic                    div_by_zero
);

  logic             signs_differ;
  logic             inexact;
  logic [WIDTH-1:0] q_next;
  logic [WIDTH-1:0] r_next;

  assign signs_differ = flags_in.neg_a ^ flags_in.neg_b;
  assign inexact      = (ur != '0);

  // Negating and then subtracting one from the quotient is its complement.
  // The corrected remainder is the divisor plus the signed truncated remainder.
  always_comb begin
    if (flags_in.zero) begin
      q_next = '0;
      r_next = '0;
    end else if (signs_differ && inexact) begin
      q_next = ~uq;
      r_next = flags_in.neg_a ? (b_in - ur) : (b_in + ur);
    end else begin
      q_next = signs_differ ? ({WIDTH{1'b0}} - uq) : uq;
      r_next = flags_in.neg_a ? ({WIDTH{1'b0}} - ur) : ur;
    end
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      quotient    <= $signed(q_next);
      remainder   <= $signed(r_next);
      div_by_zero <= flags_in.zero;
    end
  end

endmodule

FILE: hw/rtl/floor_divmod_signed_core.sv
// Signed floored divide and modulo: input stage, WIDTH division cells, output stage.
// Depends on fdm_pkg, fdm_prep, fdm_cell and fdm_post.
`timescale 1ns / 1ps

// The core accepts one transaction per clock cycle while in_stall is low and
// returns the floored quotient, a remainder with the sign of the divisor, and
// a divide-by-zero flag (quotient and remainder then read zero). One input
// stage forms operand magnitudes, a row of WIDTH restoring division cells
// develops one quotient bit each, and one output stage applies signs and
// the floor correction. Every stage holds its own transaction and stalls only
// when it is full and the stage after it stalls, so empty slots close up and
// new transactions enter while a finished result waits at the output. The
// most negative dividend over minus one wraps to the most negative quotient.

module floor_divmod_signed_core import fdm_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [WIDTH-1:0] dividend,
  input  logic signed [WIDTH-1:0] divisor,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WIDTH-1:0] quotient,
  output logic signed [WIDTH-1:0] remainder,
  output logic                    div_by_zero
);

  // Chain links: index 0 leaves the input stage, index WIDTH leaves the last cell.
  logic [WIDTH:0][WIDTH-1:0] rem_c;
  logic [WIDTH:0][WIDTH-1:0] qd_c;
  logic [WIDTH:0][WIDTH-1:0] mb_c;
  logic [WIDTH:0][WIDTH-1:0] b_c;
  fdm_flags_t [WIDTH:0]      flags_c;
  logic [WIDTH:0]            valid_c;
  logic [WIDTH:0]            stall_c;

  // Operand preparation.
  fdm_prep #(.WIDTH(WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (valid_c[0]),
    .out_stall (stall_c[0]),
    .rem       (rem_c[0]),
    .qd        (qd_c[0]),
    .mb        (mb_c[0]),
    .b         (b_c[0]),
    .flags     (flags_c[0])
  );

  // Row of division cells, most significant quotient bit first.
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    fdm_cell #(.WIDTH(WIDTH)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_c[i]),
      .in_stall  (stall_c[i]),
      .rem_in    (rem_c[i]),
      .qd_in     (qd_c[i]),
      .mb_in     (mb_c[i]),
      .b_in      (b_c[i]),
      .flags_in  (flags_c[i]),
      .out_valid (valid_c[i+1]),
      .out_stall (stall_c[i+1]),
      .rem       (rem_c[i+1]),
      .qd        (qd_c[i+1]),
      .mb        (mb_c[i+1]),
      .b         (b_c[i+1]),
      .flags     (flags_c[i+1])
    );
  end

  // Sign application and floor correction.
  fdm_post #(.WIDTH(WIDTH)) u_post (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (valid_c[WIDTH]),
    .in_stall    (stall_c[WIDTH]),
    .ur          (rem_c[WIDTH]),
    .uq          (qd_c[WIDTH]),
    .b_in        (b_c[WIDTH]),
    .flags_in    (flags_c[WIDTH]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .quotient    (quotient),
    .remainder   (remainder),
    .div_by_zero (div_by_zero)
  );

  // A stall reaches the input only when it starts at the output.
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall)
    else $error("input stalled while output was not stalled");

  // A zero divisor yields zero quotient and remainder.
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && div_by_zero) |-> (quotient == '0 && remainder == '0))
    else $error("nonzero result reported with divide by zero");

  // The pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !valid_c[0])
    else $error("transaction present right after reset");

endmodule
